[rtl/sfcc_pkg.sv]
`default_nettype none

package sfcc_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned WordWidth = 16;
   localparam int unsigned PosWidth  = 3;
   localparam int unsigned AddrWidth = 4;
   localparam int unsigned DataWidth = 32;

   localparam logic [WordWidth-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WordWidth-1:0] CRC_POLY = 16'hA001;

   // byte positions within the frame
   localparam logic [PosWidth-1:0] POS_FIRST    = 3'd0;
   localparam logic [PosWidth-1:0] POS_HUMID_HI = 3'd2;
   localparam logic [PosWidth-1:0] POS_HUMID_LO = 3'd3;
   localparam logic [PosWidth-1:0] POS_TEMP_HI  = 3'd4;
   localparam logic [PosWidth-1:0] POS_TEMP_LO  = 3'd5;
   localparam logic [PosWidth-1:0] POS_CRC_LO   = 3'd6;
   localparam logic [PosWidth-1:0] POS_CRC_HI   = 3'd7;

   // register indexes
   localparam logic [1:0] REG_TEMP_UPPER  = 2'd0;
   localparam logic [1:0] REG_TEMP_LOWER  = 2'd1;
   localparam logic [1:0] REG_HUMID_UPPER = 2'd2;
   localparam logic [1:0] REG_HUMID_LOWER = 2'd3;

   localparam logic [WordWidth-1:0] TEMP_UPPER_RESET  = 16'd400;
   localparam logic [WordWidth-1:0] TEMP_LOWER_RESET  = 16'd0;
   localparam logic [WordWidth-1:0] HUMID_UPPER_RESET = 16'd800;
   localparam logic [WordWidth-1:0] HUMID_LOWER_RESET = 16'd200;

   typedef struct packed {
      logic [ByteWidth-1:0] frame_byte;
      logic                 frame_start;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] temperature_raw;
      logic [WordWidth-1:0] humidity_raw;
      logic                 crc_ok;
      logic                 ambient_normal;
   } rsp_type;

   typedef struct packed {
      logic [WordWidth-1:0] temp_upper;
      logic [WordWidth-1:0] temp_lower;
      logic [WordWidth-1:0] humid_upper;
      logic [WordWidth-1:0] humid_lower;
   } limits_type;

   // one byte of crc-16/modbus, lsb first
   function automatic logic [WordWidth-1:0] crc_feed(
      input logic [WordWidth-1:0] crc_value,
      input logic [ByteWidth-1:0] data_byte
   );
      logic [WordWidth-1:0] c;
      c = crc_value ^ {{(WordWidth-ByteWidth){1'b0}}, data_byte};
      for (int k = 0; k < ByteWidth; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/sensor_frame_crc_checker.sv]
// Checks the 8-byte response frame of a temperature/humidity sensor, one byte per beat.
// CRC-16/Modbus runs over bytes 0-5 and is compared with the little-endian CRC in
// bytes 6-7; bytes 2-3 give humidity and 4-5 temperature, big-endian. One result
// beat follows byte 7, carrying both raw words, crc_ok and ambient_normal (both
// values strictly between their limits, in tenths). frame_start forces byte 0;
// after byte 7 the count wraps. A byte passes an input register and then crc and
// compare logic into the result register, so the block takes one byte per cycle;
// a result is registered as byte 7 leaves the input register, and the result
// register stalls only the byte 7 of a following frame. Limit registers sit at
// byte addresses 0, 4, 8, 12, to be written by the user while idle; not enforced.
`default_nettype none

module sensor_frame_crc_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire sfcc_pkg::req_type              req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      sfcc_pkg::rsp_type              rsp_data,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [sfcc_pkg::AddrWidth-1:0] csr_paddr,
   input  wire logic [sfcc_pkg::DataWidth-1:0] csr_pwdata,
   output      logic [sfcc_pkg::DataWidth-1:0] csr_prdata,
   output      logic                           csr_pready
);

   logic                 in_valid_ff, in_valid_in;
   sfcc_pkg::req_type    in_data_ff,  in_data_in;
   logic                 core_ready;
   sfcc_pkg::limits_type limits;

   assign req_ready = !in_valid_ff || core_ready;

   always_comb begin
      in_valid_in = in_valid_ff && !core_ready;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
   end

   sfcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   sfcc_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (core_ready),
      .in_data   (in_data_ff),
      .limits    (limits),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/sfcc_csr.sv]
`default_nettype none

module sfcc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [sfcc_pkg::AddrWidth-1:0]     csr_paddr,
   input  wire logic [sfcc_pkg::DataWidth-1:0]     csr_pwdata,
   output      logic [sfcc_pkg::DataWidth-1:0]     csr_prdata,
   output      logic                               csr_pready,
   output      sfcc_pkg::limits_type               limits
);

   sfcc_pkg::limits_type limits_ff;
   sfcc_pkg::limits_type limits_in;
   logic [1:0]                     reg_index;
   logic                           write_en;
   logic [sfcc_pkg::WordWidth-1:0] wdata;
   logic [sfcc_pkg::WordWidth-1:0] rdata;

   assign reg_index  = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wdata      = csr_pwdata[sfcc_pkg::WordWidth-1:0];

   always_comb begin
      limits_in = limits_ff;
      if (write_en) begin
         unique case (reg_index)
            sfcc_pkg::REG_TEMP_UPPER:  limits_in.temp_upper  = wdata;
            sfcc_pkg::REG_TEMP_LOWER:  limits_in.temp_lower  = wdata;
            sfcc_pkg::REG_HUMID_UPPER: limits_in.humid_upper = wdata;
            sfcc_pkg::REG_HUMID_LOWER: limits_in.humid_lower = wdata;
            default:                   limits_in = limits_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         sfcc_pkg::REG_TEMP_UPPER:  rdata = limits_ff.temp_upper;
         sfcc_pkg::REG_TEMP_LOWER:  rdata = limits_ff.temp_lower;
         sfcc_pkg::REG_HUMID_UPPER: rdata = limits_ff.humid_upper;
         sfcc_pkg::REG_HUMID_LOWER: rdata = limits_ff.humid_lower;
         default:                   rdata = '0;
      endcase
   end

   assign csr_prdata = {{(sfcc_pkg::DataWidth-sfcc_pkg::WordWidth){1'b0}}, rdata};
   assign limits     = limits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.temp_upper  <= sfcc_pkg::TEMP_UPPER_RESET;
         limits_ff.temp_lower  <= sfcc_pkg::TEMP_LOWER_RESET;
         limits_ff.humid_upper <= sfcc_pkg::HUMID_UPPER_RESET;
         limits_ff.humid_lower <= sfcc_pkg::HUMID_LOWER_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sfcc_frame.sv]
`default_nettype none

module sfcc_frame (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output      logic                 in_ready,
   input  wire sfcc_pkg::req_type    in_data,
   input  wire sfcc_pkg::limits_type limits,
   output      logic                 out_valid,
   input  wire logic                 out_ready,
   output      sfcc_pkg::rsp_type    out_data
);

   logic [sfcc_pkg::PosWidth-1:0]  pos_ff,       pos_in;
   logic [sfcc_pkg::WordWidth-1:0] crc_ff,       crc_in;
   logic [sfcc_pkg::WordWidth-1:0] humid_ff,     humid_in;
   logic [sfcc_pkg::WordWidth-1:0] temp_ff,      temp_in;
   logic [sfcc_pkg::ByteWidth-1:0] crc_lo_ff,    crc_lo_in;
   logic                           out_valid_ff, out_valid_in;
   sfcc_pkg::rsp_type              out_data_ff,  out_data_in;

   logic [sfcc_pkg::PosWidth-1:0]  pos;
   logic [sfcc_pkg::WordWidth-1:0] crc_base;
   logic [sfcc_pkg::WordWidth-1:0] crc_next;
   logic                           out_free;
   logic                           last_byte;
   logic                           fire;
   logic                           temp_ok;
   logic                           humid_ok;

   assign pos       = in_data.frame_start ? sfcc_pkg::POS_FIRST : pos_ff;
   assign crc_base  = (pos == sfcc_pkg::POS_FIRST) ? sfcc_pkg::CRC_INIT : crc_ff;
   assign crc_next  = (pos < sfcc_pkg::POS_CRC_LO) ?
                      sfcc_pkg::crc_feed(crc_base, in_data.frame_byte) : crc_base;
   assign out_free  = !out_valid_ff || out_ready;
   assign last_byte = (pos == sfcc_pkg::POS_CRC_HI);
   assign in_ready  = out_free || !last_byte;
   assign fire      = in_valid && in_ready;

   assign temp_ok  = (temp_ff > limits.temp_lower) && (temp_ff < limits.temp_upper);
   assign humid_ok = (humid_ff > limits.humid_lower) && (humid_ff < limits.humid_upper);

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      humid_in     = humid_ff;
      temp_in      = temp_ff;
      crc_lo_in    = crc_lo_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_data_in  = out_data_ff;
      if (fire) begin
         pos_in = pos + 1'b1;
         crc_in = crc_next;
         case (pos)
            sfcc_pkg::POS_HUMID_HI: humid_in[15:8] = in_data.frame_byte;
            sfcc_pkg::POS_HUMID_LO: humid_in[7:0]  = in_data.frame_byte;
            sfcc_pkg::POS_TEMP_HI:  temp_in[15:8]  = in_data.frame_byte;
            sfcc_pkg::POS_TEMP_LO:  temp_in[7:0]   = in_data.frame_byte;
            sfcc_pkg::POS_CRC_LO:   crc_lo_in      = in_data.frame_byte;
            sfcc_pkg::POS_CRC_HI: begin
               out_valid_in                = 1'b1;
               out_data_in.temperature_raw = temp_ff;
               out_data_in.humidity_raw    = humid_ff;
               out_data_in.crc_ok          = ({in_data.frame_byte, crc_lo_ff} == crc_next);
               out_data_in.ambient_normal  = temp_ok && humid_ok;
               crc_in                      = sfcc_pkg::CRC_INIT;
            end
            default: ;
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= sfcc_pkg::POS_FIRST;
         crc_ff       <= sfcc_pkg::CRC_INIT;
         humid_ff     <= '0;
         temp_ff      <= '0;
         crc_lo_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         humid_ff     <= humid_in;
         temp_ff      <= temp_in;
         crc_lo_ff    <= crc_lo_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire
